### hdl/sorted_table_search_unit_defines.svh
// ----------------------------------------------------------------------------
// Sorted table search assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_SEARCH_UNIT_DEFINES_SVH

// Property that must hold in the same cycle
`define STS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define STS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Sizes, function codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int KEY_W   = 64;
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;

  // Function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINAL
  } sts_state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;      // store key at index
    logic load;    // start a search, issue first probe
    logic step;    // narrow range on probe result
    logic finish;  // final compare, emit position
  } sts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic short_range;  // clamped size is 0 or 1: no narrowing needed
    logic range_done;   // range down to one entry after this step
  } sts_stat_t;

endpackage

### hdl/sts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### hdl/sts_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted table search controller
// Sequences a write, or the probe steps and final compare of a search.
// ----------------------------------------------------------------------------
module sts_ctrl import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      func,
  input  sts_stat_t stat,
  output sts_cmd_t  cmd,
  output logic      busy
);

  sts_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (func == FUNC_SEARCH)) begin
          state_nxt = stat.short_range ? ST_FINAL : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat.range_done) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.wr   = start && (func == FUNC_WRITE);
        cmd.load = start && (func == FUNC_SEARCH);
      end
      ST_SEARCH: cmd.step   = 1'b1;
      ST_FINAL:  cmd.finish = 1'b1;
      default:   busy       = 1'b1;
    endcase
  end

endmodule

### hdl/sts_dp.sv
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Key RAM, table size register, search bounds and probe address logic.
// ----------------------------------------------------------------------------
`include "sorted_table_search_unit_defines.svh"

module sts_dp import sts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sts_cmd_t                 cmd,
  output sts_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [SIZE_W-1:0]        cfg_table_size,
  input  logic [INDEX_W-1:0]       in_index,
  input  logic signed [KEY_W-1:0]  in_key,
  output logic                     out_valid,
  output logic [SIZE_W-1:0]        out_position
);

  logic [SIZE_W-1:0]       table_size_r;
  logic [CNT_W-1:0]        lo_r, hi_r;
  logic [ADDR_W-1:0]       mid_r;
  logic signed [KEY_W-1:0] key_r;
  logic                    empty_r;
  logic                    out_valid_r;
  logic [SIZE_W-1:0]       out_position_r;

  logic [CNT_W-1:0]        n_clamp;
  logic signed [KEY_W-1:0] rd_key;
  logic                    q_ge, q_gt;
  logic [CNT_W-1:0]        lo_step, hi_step, span;
  logic [CNT_W:0]          mid_sum;
  logic                    range_done;
  logic [ADDR_W-1:0]       ram_addr;
  logic                    ram_we;
  logic [CNT_W-1:0]        pos_calc;

  // Table size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_we) begin
      table_size_r <= cfg_table_size;
    end
  end

  // Sizes above the table depth search the whole table
  always_comb begin
    if (32'(table_size_r) > 32'(DEPTH)) begin
      n_clamp = CNT_W'(DEPTH);
    end else begin
      n_clamp = CNT_W'(table_size_r);
    end
  end

  // Key RAM
  assign ram_we = cmd.wr && (32'(in_index) < 32'(DEPTH));

  sts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_key),
    .rdata (rd_key)
  );

  // Probe compare and narrowed bounds
  assign q_ge    = key_r >= rd_key;
  assign q_gt    = key_r > rd_key;
  assign lo_step = q_ge ? CNT_W'(mid_r) : lo_r;
  assign hi_step = q_ge ? hi_r : CNT_W'(mid_r);
  assign span    = hi_step - lo_step;
  assign mid_sum = {1'b0, hi_step} + {1'b0, lo_step};
  assign range_done = span <= CNT_W'(1);

  assign stat.short_range = n_clamp <= CNT_W'(1);
  assign stat.range_done  = range_done;

  // Next RAM address: write index, first probe, next probe or final entry
  always_comb begin
    ram_addr = mid_r;
    if (cmd.wr) begin
      ram_addr = ADDR_W'(in_index);
    end else if (cmd.load) begin
      ram_addr = ADDR_W'(n_clamp >> 1);
    end else if (cmd.step) begin
      ram_addr = range_done ? ADDR_W'(lo_step) : ADDR_W'(mid_sum >> 1);
    end
  end

  // Search bounds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r    <= '0;
      hi_r    <= n_clamp;
      key_r   <= in_key;
      empty_r <= n_clamp == '0;
    end else if (cmd.step) begin
      lo_r <= lo_step;
      hi_r <= hi_step;
    end
    if (cmd.load || cmd.step) begin
      mid_r <= ram_addr;
    end
  end

  // Final compare against the entry at lo
  assign pos_calc = empty_r ? '0 : (lo_r + CNT_W'(q_gt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_position_r <= SIZE_W'(pos_calc);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;

  // Checks
  `STS_CHECK(a_step_span, !cmd.step || ((hi_r - lo_r) > CNT_W'(1)), "step on collapsed range")
  `STS_CHECK(a_final_order, !cmd.finish || empty_r || (lo_r < hi_r), "final with lo not below hi")
  `STS_CHECK_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `STS_CHECK(a_pos_bound, !out_valid_r || (32'(out_position_r) <= 32'(DEPTH)), "position past depth")

endmodule

### hdl/sorted_table_search_unit.sv
// ----------------------------------------------------------------------------
// Sorted table search unit
// Binary search for the insertion point of a key in an ascending key table.
//
//   channel   | ports                                  | handshake
//   ----------+----------------------------------------+--------------------
//   input     | in_func, in_index, in_key              | start && !busy
//   result    | out_position                           | out_valid strobe
//   config    | cfg_table_size                         | cfg_valid, cfg_ready
//
// During a write busy stays low. A search holds busy through its probe steps,
// one probe per cycle, set by the registered read of the single-port key RAM,
// then the final compare; with n the clamped table size, a search with n of 0
// or 1 skips the probes and does only the final compare. The result strobes in
// the first cycle with busy low again and is never stalled. Reset is
// synchronous, active low, and clears the table size and the controller; key
// RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_search_unit import sts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [INDEX_W-1:0]      in_index,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic [SIZE_W-1:0]       out_position,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SIZE_W-1:0]       cfg_table_size
);

  sts_cmd_t  cmd;
  sts_stat_t stat;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  sts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_table_size (cfg_table_size),
    .in_index       (in_index),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_position   (out_position)
  );

endmodule
